// File: src/irtcd_pkg.sv
// Package with shared constants for the IR touch calibration and press detector.
`default_nettype none

package irtcd_pkg;

    localparam int unsigned SAMPLE_W = 10;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned THR_W    = 11;
    localparam int unsigned RUNMIN_W = 11;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned OUT_TDATA_W = 24;

    localparam logic [TIME_W-1:0]   LONG_PRESS_MS    = 32'd3000;
    localparam logic [TIME_W-1:0]   LOCKOUT_MS       = 32'd1500;
    localparam logic [TIME_W-1:0]   HELD_RELEASE_MS  = 32'd200;
    localparam logic [TIME_W-1:0]   COUNT_RELEASE_MS = 32'd500;
    localparam logic [RUNMIN_W-1:0] MIN_RESET        = 11'd1025;
    localparam logic [THR_W-1:0]    THR_MAX          = 11'd1024;
    localparam logic [TIME_W-1:0]   BLINK_START_MS   = 32'd3000;
    localparam logic [COUNT_W-1:0]  COUNT_SAT        = 8'd255;

    localparam logic [CFG_IDX_W-1:0] REG_STABLE_MAX_CHANGE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CALIB_REPEATS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE_Q8_8         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_OFFSET   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BASE_LEVEL     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_COUNT_NEEDED = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_ON_MS        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_OFF_MS       = 3'd7;

    localparam logic [9:0]         RST_STABLE_MAX_CHANGE  = 10'd10;
    localparam logic [7:0]         RST_CALIB_REPEATS      = 8'd20;
    localparam logic signed [15:0] RST_SLOPE_Q8_8         = -16'sd256;
    localparam logic [11:0]        RST_THRESHOLD_OFFSET   = 12'd1023;
    localparam logic [9:0]         RST_MAX_BASE_LEVEL     = 10'd900;
    localparam logic [7:0]         RST_PRESS_COUNT_NEEDED = 8'd3;
    localparam logic [15:0]        RST_BLINK_ON_MS        = 16'd100;
    localparam logic [15:0]        RST_BLINK_OFF_MS       = 16'd2000;

endpackage

`default_nettype wire

// File: src/ir_touch_calibrate_detect.sv
// IR touch sensor auto-calibration and press detection, top level.
// A result appears on the master side in the cycle after its input transaction.
// Throughput: one input transaction per cycle; all work is one registered single pass.
// The slave side stays ready while the output register is empty or being taken.
// Reset is synchronous and active low; it restores the register defaults and all state but the output data.
`default_nettype none

module ir_touch_calibrate_detect (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // tdata: ir_sample [9:0], now_ms [41:10], zero fill [47:42]
    input  wire logic [irtcd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: press_event [0], long_press_release [1], calib_error [2],
    // newly_calibrated [3], is_calibrated [4], blink_phase [5],
    // press_threshold [16:6], zero fill [23:17]
    output logic [irtcd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic        i_cfg_valid,
    input  wire logic [irtcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [irtcd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic             o_cfg_ready
);

    // Configuration registers
    logic [9:0]         r_stable_max_change;
    logic [7:0]         r_calib_repeats;
    logic signed [15:0] r_slope;
    logic [11:0]        r_threshold_offset;
    logic [9:0]         r_max_base_level;
    logic [7:0]         r_press_count_needed;
    logic [15:0]        r_blink_on_ms;
    logic [15:0]        r_blink_off_ms;

    // State
    logic [irtcd_pkg::SAMPLE_W-1:0] r_prev, n_prev;
    logic [irtcd_pkg::RUNMIN_W-1:0] r_run_min, n_run_min;
    logic [irtcd_pkg::SAMPLE_W-1:0] r_run_max, n_run_max;
    logic [irtcd_pkg::COUNT_W-1:0]  r_stable_count, n_stable_count;
    logic [irtcd_pkg::THR_W-1:0]    r_threshold, n_threshold;
    logic                           r_calibrated, n_calibrated;
    logic                           r_ever_cal, n_ever_cal;
    logic                           r_blink, n_blink;
    logic [irtcd_pkg::TIME_W-1:0]   r_next_blink, n_next_blink;
    logic [irtcd_pkg::TIME_W-1:0]   r_calib_lock, n_calib_lock;
    logic [irtcd_pkg::TIME_W-1:0]   r_press_lock, n_press_lock;
    logic [irtcd_pkg::COUNT_W-1:0]  r_press_counter, n_press_counter;
    logic [irtcd_pkg::TIME_W-1:0]   r_last_seen, n_last_seen;
    logic [irtcd_pkg::TIME_W-1:0]   r_press_start, n_press_start;

    logic                                r_out_valid;
    logic [irtcd_pkg::OUT_TDATA_W-1:0]   r_out_data, n_out_data;

    // Working signals
    logic                           in_accept;
    logic [irtcd_pkg::SAMPLE_W-1:0] sample;
    logic [irtcd_pkg::TIME_W-1:0]   now;
    logic [irtcd_pkg::RUNMIN_W-1:0] sample_ext;
    logic                           cal_run;
    logic [irtcd_pkg::SAMPLE_W-1:0] diff;
    logic                           is_stable;
    logic [irtcd_pkg::COUNT_W-1:0]  count1;
    logic [irtcd_pkg::RUNMIN_W-1:0] min1;
    logic [irtcd_pkg::SAMPLE_W-1:0] max1;
    logic                           attempt;
    logic                           range_bad;
    logic [11:0]                    mid_sum;
    logic [9:0]                     mid;
    logic signed [26:0]             prod;
    logic signed [18:0]             scaled;
    logic signed [19:0]             thr_raw;
    logic [irtcd_pkg::THR_W-1:0]    thr_sat;
    logic                           calib_err;
    logic                           newly_cal;
    logic                           det_run;
    logic                           over_thr;
    logic [irtcd_pkg::COUNT_W-1:0]  count_inc;
    logic                           press_evt;
    logic                           long_rel;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign o_cfg_ready   = 1'b1;

    assign sample     = s_axis_tdata[9:0];
    assign now        = s_axis_tdata[41:10];
    assign sample_ext = {1'b0, sample};

    // Threshold arithmetic from the midpoint
    assign mid_sum = {2'b00, max1} + {1'b0, min1};
    assign mid     = mid_sum[10:1];
    assign prod    = $signed({1'b0, mid}) * r_slope;
    assign scaled  = prod[26:8];
    assign thr_raw = {scaled[18], scaled} + $signed({8'b0, r_threshold_offset});

    always_comb begin
        if (thr_raw < 20'sd0) begin
            thr_sat = '0;
        end else if (thr_raw > $signed({9'b0, irtcd_pkg::THR_MAX})) begin
            thr_sat = irtcd_pkg::THR_MAX;
        end else begin
            thr_sat = thr_raw[10:0];
        end
    end

    // Calibration stage
    always_comb begin
        cal_run   = !(now < r_calib_lock);
        diff      = (sample > r_prev) ? (sample - r_prev) : (r_prev - sample);
        is_stable = diff < r_stable_max_change;
        if (is_stable) begin
            count1 = (r_stable_count != irtcd_pkg::COUNT_SAT) ? r_stable_count + 8'd1
                                                              : r_stable_count;
            min1   = (sample_ext < r_run_min) ? sample_ext : r_run_min;
            max1   = (sample > r_run_max) ? sample : r_run_max;
        end else begin
            count1 = '0;
            min1   = sample_ext;
            max1   = sample;
        end
        attempt   = count1 >= r_calib_repeats;
        range_bad = ({1'b0, max1} >= min1)
                    && (({1'b0, max1} - min1) >= {1'b0, r_stable_max_change});

        n_blink        = r_blink;
        n_next_blink   = r_next_blink;
        n_prev         = r_prev;
        n_run_min      = r_run_min;
        n_run_max      = r_run_max;
        n_stable_count = r_stable_count;
        n_threshold    = r_threshold;
        n_calibrated   = r_calibrated;
        n_ever_cal     = r_ever_cal;
        calib_err      = 1'b0;
        newly_cal      = 1'b0;

        if (cal_run && !r_ever_cal && (now > r_next_blink)) begin
            n_blink      = !r_blink;
            n_next_blink = r_next_blink + (n_blink ? {16'b0, r_blink_on_ms}
                                                   : {16'b0, r_blink_off_ms});
        end

        if (cal_run && (r_press_counter == '0)) begin
            if (attempt && range_bad) begin
                n_stable_count = '0;
                n_run_min      = sample_ext;
                n_run_max      = sample;
            end else begin
                n_prev = sample;
                if (attempt) begin
                    if (mid > r_max_base_level) begin
                        calib_err    = 1'b1;
                        n_calibrated = 1'b0;
                    end else begin
                        newly_cal    = !r_calibrated;
                        n_calibrated = 1'b1;
                        n_ever_cal   = 1'b1;
                        n_threshold  = thr_sat;
                    end
                    n_stable_count = '0;
                    n_run_min      = irtcd_pkg::MIN_RESET;
                    n_run_max      = '0;
                end else begin
                    n_stable_count = count1;
                    n_run_min      = min1;
                    n_run_max      = max1;
                end
            end
        end
    end

    // Press stage, working on the state left by the calibration stage
    always_comb begin
        det_run   = n_calibrated && !(now < r_press_lock);
        over_thr  = {1'b0, sample} >= n_threshold;
        count_inc = r_press_counter + 8'd1;

        n_press_counter = r_press_counter;
        n_last_seen     = r_last_seen;
        n_press_start   = r_press_start;
        n_calib_lock    = r_calib_lock;
        n_press_lock    = r_press_lock;
        press_evt       = 1'b0;
        long_rel        = 1'b0;

        if (det_run) begin
            if (r_press_counter == r_press_count_needed) begin
                if (over_thr) begin
                    n_last_seen = now;
                    if (now > r_press_start + irtcd_pkg::LONG_PRESS_MS) begin
                        n_press_counter = '0;
                        n_calib_lock    = now + irtcd_pkg::LOCKOUT_MS;
                        n_press_lock    = now + irtcd_pkg::LOCKOUT_MS;
                        long_rel        = 1'b1;
                    end
                end else if (now > r_last_seen + irtcd_pkg::HELD_RELEASE_MS) begin
                    n_press_counter = '0;
                end
            end else if (over_thr) begin
                n_press_counter = count_inc;
                n_last_seen     = now;
                if (count_inc == r_press_count_needed) begin
                    n_press_start = now;
                    press_evt     = 1'b1;
                end
            end else if (now > r_last_seen + irtcd_pkg::COUNT_RELEASE_MS) begin
                n_press_counter = '0;
            end
        end

        n_out_data = {7'b0, n_threshold, n_blink, n_calibrated, newly_cal, calib_err,
                      long_rel, press_evt};
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_max_change  <= irtcd_pkg::RST_STABLE_MAX_CHANGE;
            r_calib_repeats      <= irtcd_pkg::RST_CALIB_REPEATS;
            r_slope              <= irtcd_pkg::RST_SLOPE_Q8_8;
            r_threshold_offset   <= irtcd_pkg::RST_THRESHOLD_OFFSET;
            r_max_base_level     <= irtcd_pkg::RST_MAX_BASE_LEVEL;
            r_press_count_needed <= irtcd_pkg::RST_PRESS_COUNT_NEEDED;
            r_blink_on_ms        <= irtcd_pkg::RST_BLINK_ON_MS;
            r_blink_off_ms       <= irtcd_pkg::RST_BLINK_OFF_MS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                irtcd_pkg::REG_STABLE_MAX_CHANGE:  r_stable_max_change  <= i_cfg_data[9:0];
                irtcd_pkg::REG_CALIB_REPEATS:      r_calib_repeats      <= i_cfg_data[7:0];
                irtcd_pkg::REG_SLOPE_Q8_8:         r_slope              <= $signed(i_cfg_data);
                irtcd_pkg::REG_THRESHOLD_OFFSET:   r_threshold_offset   <= i_cfg_data[11:0];
                irtcd_pkg::REG_MAX_BASE_LEVEL:     r_max_base_level     <= i_cfg_data[9:0];
                irtcd_pkg::REG_PRESS_COUNT_NEEDED: r_press_count_needed <= i_cfg_data[7:0];
                irtcd_pkg::REG_BLINK_ON_MS:        r_blink_on_ms        <= i_cfg_data;
                irtcd_pkg::REG_BLINK_OFF_MS:       r_blink_off_ms       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev          <= '0;
            r_run_min       <= irtcd_pkg::MIN_RESET;
            r_run_max       <= '0;
            r_stable_count  <= '0;
            r_threshold     <= '0;
            r_calibrated    <= 1'b0;
            r_ever_cal      <= 1'b0;
            r_blink         <= 1'b1;
            r_next_blink    <= irtcd_pkg::BLINK_START_MS;
            r_calib_lock    <= '0;
            r_press_lock    <= '0;
            r_press_counter <= '0;
            r_last_seen     <= '0;
            r_press_start   <= '0;
        end else if (in_accept) begin
            r_prev          <= n_prev;
            r_run_min       <= n_run_min;
            r_run_max       <= n_run_max;
            r_stable_count  <= n_stable_count;
            r_threshold     <= n_threshold;
            r_calibrated    <= n_calibrated;
            r_ever_cal      <= n_ever_cal;
            r_blink         <= n_blink;
            r_next_blink    <= n_next_blink;
            r_calib_lock    <= n_calib_lock;
            r_press_lock    <= n_press_lock;
            r_press_counter <= n_press_counter;
            r_last_seen     <= n_last_seen;
            r_press_start   <= n_press_start;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= n_out_data;
        end
    end

    // Assertions
    a_cal_implies_ever: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_calibrated |-> r_ever_cal)
        else $error("Calibrated flag set without a past calibration.");

    a_thr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_threshold <= irtcd_pkg::THR_MAX)
        else $error("Press threshold out of range.");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> m_axis_tvalid)
        else $error("No result after an input transaction.");

    a_long_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && long_rel) |=> (r_press_counter == '0) && (r_press_lock == r_calib_lock))
        else $error("Long press release left detection active or locks unequal.");

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the IR touch calibration and press detector.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic        press_event;
        logic        long_press_release;
        logic        calib_error;
        logic        newly_calibrated;
        logic        is_calibrated;
        logic        blink_phase;
        logic [10:0] press_threshold;
    } t_touch_result;

    logic                              i_clk;
    logic                              i_rst_n;
    logic [irtcd_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [irtcd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic                              i_cfg_valid;
    logic [irtcd_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [irtcd_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                              o_cfg_ready;

    int sender_idle_pct = 9;
    int receiver_idle_pct = 72;
    int mismatch_count = 0;
    logic [31:0] stamp_ms = '0;

    t_touch_result touch_expected_q[$];

    // Register copies.
    logic [9:0]         stable_band;
    logic [7:0]         repeats_needed;
    logic signed [15:0] slope_q8;
    logic [11:0]        level_offset;
    logic [9:0]         base_limit;
    logic [7:0]         touches_needed;
    logic [15:0]        blink_on_ms;
    logic [15:0]        blink_off_ms;

    // Detector state.
    logic [9:0]  last_sample;
    logic [10:0] low_mark;
    logic [9:0]  high_mark;
    logic [7:0]  steady_count;
    logic [10:0] press_level;
    logic        calibrated;
    logic        calibrated_once;
    logic        white_on;
    logic [31:0] blink_due_ms;
    logic [31:0] calib_hold_ms;
    logic [31:0] press_hold_ms;
    logic [7:0]  touch_count;
    logic [31:0] last_touch_ms;
    logic [31:0] touch_start_ms;

    ir_touch_calibrate_detect u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_cfg_ready   (o_cfg_ready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void reset_touch_model();
        stable_band     = irtcd_pkg::RST_STABLE_MAX_CHANGE;
        repeats_needed  = irtcd_pkg::RST_CALIB_REPEATS;
        slope_q8        = irtcd_pkg::RST_SLOPE_Q8_8;
        level_offset    = irtcd_pkg::RST_THRESHOLD_OFFSET;
        base_limit      = irtcd_pkg::RST_MAX_BASE_LEVEL;
        touches_needed  = irtcd_pkg::RST_PRESS_COUNT_NEEDED;
        blink_on_ms     = irtcd_pkg::RST_BLINK_ON_MS;
        blink_off_ms    = irtcd_pkg::RST_BLINK_OFF_MS;
        last_sample     = '0;
        low_mark        = irtcd_pkg::MIN_RESET;
        high_mark       = '0;
        steady_count    = '0;
        press_level     = '0;
        calibrated      = 1'b0;
        calibrated_once = 1'b0;
        white_on        = 1'b1;
        blink_due_ms    = irtcd_pkg::BLINK_START_MS;
        calib_hold_ms   = '0;
        press_hold_ms   = '0;
        touch_count     = '0;
        last_touch_ms   = '0;
        touch_start_ms  = '0;
    endfunction

    function automatic void apply_touch_register(
        input logic [irtcd_pkg::CFG_IDX_W-1:0] index,
        input logic [irtcd_pkg::CFG_DATA_W-1:0] value);
        case (index)
            irtcd_pkg::REG_STABLE_MAX_CHANGE:  stable_band    = value[9:0];
            irtcd_pkg::REG_CALIB_REPEATS:      repeats_needed = value[7:0];
            irtcd_pkg::REG_SLOPE_Q8_8:         slope_q8       = value;
            irtcd_pkg::REG_THRESHOLD_OFFSET:   level_offset   = value[11:0];
            irtcd_pkg::REG_MAX_BASE_LEVEL:     base_limit     = value[9:0];
            irtcd_pkg::REG_PRESS_COUNT_NEEDED: touches_needed = value[7:0];
            irtcd_pkg::REG_BLINK_ON_MS:        blink_on_ms    = value;
            irtcd_pkg::REG_BLINK_OFF_MS:       blink_off_ms   = value;
            default: ;
        endcase
    endfunction

    // The product is floored by the arithmetic shift, then the sum is clamped.
    function automatic logic [10:0] press_level_for_base(input logic [10:0] base);
        int scaled;
        int level;
        scaled = (int'(base) * int'(slope_q8)) >>> 8;
        level = scaled + int'(level_offset);
        if (level < 0)
            level = 0;
        else if (level > int'(irtcd_pkg::THR_MAX))
            level = int'(irtcd_pkg::THR_MAX);
        return 11'(level);
    endfunction

    function automatic t_touch_result advance_touch_model(input logic [9:0] sample,
                                                          input logic [31:0] now);
        t_touch_result r;
        logic [9:0]  diff;
        logic [11:0] base;
        logic        restarted;
        r = '0;
        restarted = 1'b0;
        if (now >= calib_hold_ms) begin
            if (!calibrated_once && now > blink_due_ms) begin
                white_on = !white_on;
                blink_due_ms = blink_due_ms + (white_on ? {16'd0, blink_on_ms}
                                                        : {16'd0, blink_off_ms});
            end
            if (touch_count == 8'd0) begin
                diff = (sample > last_sample) ? sample - last_sample : last_sample - sample;
                if (diff < stable_band) begin
                    if (steady_count != irtcd_pkg::COUNT_SAT)
                        steady_count = steady_count + 8'd1;
                    if ({1'b0, sample} < low_mark)
                        low_mark = {1'b0, sample};
                    if (sample > high_mark)
                        high_mark = sample;
                end else begin
                    steady_count = '0;
                    low_mark = {1'b0, sample};
                    high_mark = sample;
                end
                if (steady_count >= repeats_needed) begin
                    if ({1'b0, high_mark} >= low_mark &&
                        {1'b0, high_mark} - low_mark >= {1'b0, stable_band}) begin
                        steady_count = '0;
                        low_mark = {1'b0, sample};
                        high_mark = sample;
                        restarted = 1'b1;
                    end else begin
                        base = ({1'b0, low_mark} + {2'b0, high_mark}) >> 1;
                        if (base > {2'b0, base_limit}) begin
                            r.calib_error = 1'b1;
                            calibrated = 1'b0;
                        end else begin
                            if (!calibrated)
                                r.newly_calibrated = 1'b1;
                            calibrated = 1'b1;
                            calibrated_once = 1'b1;
                            press_level = press_level_for_base(base[10:0]);
                        end
                        steady_count = '0;
                        low_mark = irtcd_pkg::MIN_RESET;
                        high_mark = '0;
                    end
                end
                if (!restarted)
                    last_sample = sample;
            end
        end
        if (calibrated && now >= press_hold_ms) begin
            if (touch_count == touches_needed) begin
                if ({1'b0, sample} >= press_level) begin
                    last_touch_ms = now;
                    if (now > touch_start_ms + irtcd_pkg::LONG_PRESS_MS) begin
                        touch_count = '0;
                        calib_hold_ms = now + irtcd_pkg::LOCKOUT_MS;
                        press_hold_ms = calib_hold_ms;
                        r.long_press_release = 1'b1;
                    end
                end else if (now > last_touch_ms + irtcd_pkg::HELD_RELEASE_MS) begin
                    touch_count = '0;
                end
            end else if ({1'b0, sample} >= press_level) begin
                touch_count = touch_count + 8'd1;
                last_touch_ms = now;
                if (touch_count == touches_needed) begin
                    touch_start_ms = now;
                    r.press_event = 1'b1;
                end
            end else if (now > last_touch_ms + irtcd_pkg::COUNT_RELEASE_MS) begin
                touch_count = '0;
            end
        end
        r.is_calibrated = calibrated;
        r.blink_phase = white_on;
        r.press_threshold = press_level;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned expd,
                                        input int unsigned got);
        if (expd != got) begin
            $error("%s: expected %0d, actual %0d", name, expd, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_touch_result expd;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                touch_expected_q.push_back(advance_touch_model(s_axis_tdata[9:0],
                                                               s_axis_tdata[41:10]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (touch_expected_q.size() == 0) begin
                    $error("Result transaction arrived with nothing expected");
                    mismatch_count++;
                end else begin
                    expd = touch_expected_q.pop_front();
                    check_field("press_event", expd.press_event, m_axis_tdata[0]);
                    check_field("long_press_release", expd.long_press_release,
                                m_axis_tdata[1]);
                    check_field("calib_error", expd.calib_error, m_axis_tdata[2]);
                    check_field("newly_calibrated", expd.newly_calibrated, m_axis_tdata[3]);
                    check_field("is_calibrated", expd.is_calibrated, m_axis_tdata[4]);
                    check_field("blink_phase", expd.blink_phase, m_axis_tdata[5]);
                    check_field("press_threshold", expd.press_threshold, m_axis_tdata[16:6]);
                end
            end
        end
    end

    initial begin
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    task automatic step_touch_sample(input logic [9:0] sample, input logic [31:0] dt);
        stamp_ms = stamp_ms + dt;
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, stamp_ms, sample};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // The block answers every sample in the cycle after it is taken, so a short pause
    // after the last result leaves it idle.
    task automatic settle_touch_block();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (touch_expected_q.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_touch_register(input logic [irtcd_pkg::CFG_IDX_W-1:0] index,
                                        input logic [irtcd_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_touch_register(index, value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Bits above each narrower register's width carry junk that the block must drop.
    task automatic program_touch_config(input int band, input int repeats, input int slope,
                                        input int offset, input int limit, input int needed,
                                        input int on_ms, input int off_ms);
        write_touch_register(irtcd_pkg::REG_STABLE_MAX_CHANGE, {6'($urandom), 10'(band)});
        write_touch_register(irtcd_pkg::REG_CALIB_REPEATS, {8'($urandom), 8'(repeats)});
        write_touch_register(irtcd_pkg::REG_SLOPE_Q8_8, 16'(slope));
        write_touch_register(irtcd_pkg::REG_THRESHOLD_OFFSET, {4'($urandom), 12'(offset)});
        write_touch_register(irtcd_pkg::REG_MAX_BASE_LEVEL, {6'($urandom), 10'(limit)});
        write_touch_register(irtcd_pkg::REG_PRESS_COUNT_NEEDED, {8'($urandom), 8'(needed)});
        write_touch_register(irtcd_pkg::REG_BLINK_ON_MS, 16'(on_ms));
        write_touch_register(irtcd_pkg::REG_BLINK_OFF_MS, 16'(off_ms));
    endtask

    task automatic test_blink_timer();
        // Alternating extremes never stay stable long enough to calibrate, so only the blink timer moves.
        step_touch_sample(10'd0, 32'd0);
        step_touch_sample(10'd1023, 32'd3000);
        step_touch_sample(10'd0, 32'd1);
        step_touch_sample(10'd1023, 32'd1999);
        step_touch_sample(10'd0, 32'd1);
        step_touch_sample(10'd1023, 32'd101);
        settle_touch_block();
        write_touch_register(irtcd_pkg::REG_BLINK_ON_MS, 16'd0);
        write_touch_register(irtcd_pkg::REG_BLINK_OFF_MS, 16'hFFFF);
        step_touch_sample(10'd0, 32'd2001);
        step_touch_sample(10'd1023, 32'd1);
        step_touch_sample(10'd0, 32'd65534);
        settle_touch_block();
    endtask

    task automatic test_calibration();
        program_touch_config(10, 2, -256, 1023, 900, 3, 100, 2000);
        // Stable steps whose span grows too wide restart the run.
        step_touch_sample(10'd100, 32'd10);
        step_touch_sample(10'd109, 32'd10);
        step_touch_sample(10'd118, 32'd10);
        // Too little IR fails the attempt.
        repeat (3) step_touch_sample(10'd1000, 32'd10);
        step_touch_sample(10'd500, 32'd10);
        step_touch_sample(10'd502, 32'd10);
        step_touch_sample(10'd501, 32'd10);
        settle_touch_block();
    endtask

    task automatic test_press_release();
        repeat (3) step_touch_sample(10'd1023, 32'd10);
        step_touch_sample(10'd100, 32'd250);
        step_touch_sample(10'd1023, 32'd10);
        step_touch_sample(10'd100, 32'd600);
        settle_touch_block();
    endtask

    task automatic test_long_press();
        repeat (3) step_touch_sample(10'd1023, 32'd10);
        step_touch_sample(10'd1023, 32'd3100);
        step_touch_sample(10'd1023, 32'd100);
        step_touch_sample(10'd600, 32'd1500);
        settle_touch_block();
    endtask

    task automatic test_register_extremes();
        // Zero repeats attempt on every step and both clamp limits are reached.
        program_touch_config(1023, 0, -32768, 4095, 1023, 0, 65535, 0);
        step_touch_sample(10'd10, 32'd10);
        step_touch_sample(10'd500, 32'd10);
        settle_touch_block();
        program_touch_config(0, 255, 32767, 0, 0, 255, 0, 65535);
        step_touch_sample(10'd0, 32'd10);
        step_touch_sample(10'd1023, 32'd10);
        settle_touch_block();
        program_touch_config(1023, 1, 32767, 0, 0, 3, 100, 2000);
        step_touch_sample(10'd0, 32'd4000);
        step_touch_sample(10'd7, 32'd10);
        settle_touch_block();
    endtask

    task automatic randomize_touch_config(input bit extreme);
        if (extreme)
            program_touch_config($urandom_range(1) ? 1023 : 0, $urandom_range(1) ? 255 : 0,
                                 $urandom_range(1) ? 32767 : -32768,
                                 $urandom_range(1) ? 4095 : 0, $urandom_range(1) ? 1023 : 0,
                                 $urandom_range(1) ? 255 : 0, $urandom_range(1) ? 65535 : 0,
                                 $urandom_range(1) ? 65535 : 0);
        else
            program_touch_config($urandom_range(60, 4), $urandom_range(12, 1),
                                 -int'($urandom_range(512, 64)), $urandom_range(1400, 700),
                                 $urandom_range(1023, 500), $urandom_range(6, 1),
                                 $urandom_range(65535), $urandom_range(65535));
    endtask

    // One touch episode: a calm stretch, long enough to calibrate when at most 30 repeats
    // are needed, usually a press or a long hold, a release gap and sometimes raw noise.
    task automatic send_touch_session(output int sent);
        int spread;
        int level;
        int span;
        int count;
        int i;
        int sample;
        bit long_hold;
        sent = 0;
        case ($urandom_range(19))
            0: stamp_ms = $urandom();
            1: stamp_ms = 32'hFFFF_FFFF - $urandom_range(4000);
            default: ;
        endcase
        spread = (stable_band > 1) ? $urandom_range((stable_band > 41) ? 40 : stable_band - 1)
                                   : 0;
        level = ($urandom_range(7) == 0) ? $urandom_range(1023 - spread)
                                         : $urandom_range(700, 150);
        count = ((repeats_needed < 30) ? repeats_needed : 30) + $urandom_range(4, 1);
        for (i = 0; i < count; i++)
            step_touch_sample(10'(level + $urandom_range(spread)), $urandom_range(30, 1));
        sent += count;
        if ($urandom_range(3) != 0) begin
            long_hold = ($urandom_range(4) == 0);
            span = (press_level <= 11'd1023) ? press_level : 900;
            count = long_hold ? $urandom_range(30, 16)
                              : $urandom_range((touches_needed < 10) ? touches_needed + 2 : 12, 1);
            for (i = 0; i < count; i++) begin
                sample = $urandom_range(1023, span);
                if (span > 0 && $urandom_range(9) == 0)
                    sample = $urandom_range(span - 1);
                step_touch_sample(10'(sample), long_hold ? $urandom_range(250, 150)
                                                         : $urandom_range(60, 5));
            end
            sent += count;
        end
        count = $urandom_range(4, 1);
        for (i = 0; i < count; i++)
            step_touch_sample(10'(level + $urandom_range(spread)),
                              $urandom_range(1) ? $urandom_range(150, 1)
                                                : $urandom_range(700, 150));
        sent += count;
        if ($urandom_range(5) == 0) begin
            count = $urandom_range(3, 1);
            for (i = 0; i < count; i++)
                step_touch_sample(10'($urandom()), $urandom_range(1000));
            sent += count;
        end
    endtask

    task automatic test_random_sessions(input int send_idle, input int take_idle,
                                        input int item_total);
        int done;
        int chunk_done;
        int sent;
        int chunk;
        sender_idle_pct = send_idle;
        receiver_idle_pct = take_idle;
        done = 0;
        chunk = 0;
        while (done < item_total) begin
            settle_touch_block();
            randomize_touch_config(chunk == 2);
            chunk_done = 0;
            while (chunk_done < 150 && done + chunk_done < item_total) begin
                send_touch_session(sent);
                chunk_done += sent;
            end
            done += chunk_done;
            chunk++;
        end
        settle_touch_block();
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = irtcd_pkg::REG_STABLE_MAX_CHANGE;
        i_cfg_data = '0;
        reset_touch_model();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_blink_timer();
        test_calibration();
        test_press_release();
        test_long_press();
        test_register_extremes();
        test_random_sessions(9, 72, 570);
        test_random_sessions(72, 9, 570);
        test_random_sessions(0, 0, 570);

        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && touch_expected_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
src/irtcd_pkg.sv
src/ir_touch_calibrate_detect.sv
test/testbench.sv
